// File: sv/fbpa_pkg.sv
// Shared types, codes and reset constants of the fixed block pool allocator.
package fbpa_pkg;

    // Default pool depth of the link memory.
    localparam int MAX_BLOCKS_DEF = 1024;

    // Reset values of the configuration registers.
    localparam logic [15:0] BLOCK_SIZE_RST    = 16'd16;
    localparam logic [10:0] BLOCK_COUNT_RST   = 11'd1024;
    localparam logic [12:0] MAX_ALIGNMENT_RST = 13'd16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BLOCK_SIZE    = 2'd0;
    localparam logic [1:0] CFG_BLOCK_COUNT   = 2'd1;
    localparam logic [1:0] CFG_MAX_ALIGNMENT = 2'd2;

    // Request modes.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_ZERO_SIZE   = 4'd1,
        ST_UNCONFIG    = 4'd2,
        ST_ALIGNMENT   = 4'd3,
        ST_TOO_BIG     = 4'd4,
        ST_EMPTY       = 4'd5,
        ST_FATAL_EMPTY = 4'd6,
        ST_OUTSIDE     = 4'd7,
        ST_DOUBLE_FREE = 4'd8,
        ST_NULL_IGNORE = 4'd9
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // One request item.
    typedef struct packed {
        logic        mode;
        logic [15:0] req_size;
        logic [12:0] req_alignment;
        logic        zero_fill;
        logic        no_fail;
        logic        handle_present;
        logic [9:0]  free_index;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [3:0]  status;
        logic [9:0]  block_index;
        logic [15:0] clear_length;
        logic [10:0] free_blocks;
        logic [10:0] used_blocks;
    } t_result;

endpackage

// File: sv/fbpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module fbpa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/fixed_block_pool_allocator.sv
// Fixed block pool allocator: free-list stack in a link memory plus a never-used pointer.
// o_done is registered from the execute state and is high for one cycle.
// A new item is taken only in the idle state, not while the previous item executes.
// The receiver cannot stall; busy stays high for the cycle after each start transfer.
// Reset (synchronous, active low) restores the register defaults and marks all blocks free.
// The link memory is not cleared; entries are only used after a free has written them.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  fbpa_pkg::t_item   i_item,
    output logic              o_done,
    output fbpa_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int IW = $clog2(MAX_BLOCKS + 1);
    localparam logic [IW-1:0] END_MARK = IW'(MAX_BLOCKS);

    // Effective block count: zero when unconfigured, saturated to the pool depth.
    function automatic logic [10:0] f_eff(input logic [15:0] bs, input logic [10:0] bc);
        logic [10:0] v;
        if (bs == 16'd0 || bc == 11'd0) begin
            v = 11'd0;
        end else if (32'(bc) > MAX_BLOCKS) begin
            v = 11'(MAX_BLOCKS);
        end else begin
            v = bc;
        end
        return v;
    endfunction

    fbpa_pkg::t_state  r_state, n_state;
    fbpa_pkg::t_item   r_item;
    fbpa_pkg::t_result r_result, n_result;
    logic              r_done, n_done;
    logic [15:0]       r_block_size, n_block_size;
    logic [10:0]       r_block_count, n_block_count;
    logic [12:0]       r_max_align, n_max_align;
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_untouched, n_untouched;
    logic [10:0]       r_free, n_free;
    logic [10:0]       count;
    logic              accept;
    logic              cfg_write;
    logic              rd_en;
    logic              wr_en;
    logic [IW-1:0]     rd_data;
    logic [IW-1:0]     pick;
    fbpa_pkg::t_status status;

    assign accept    = start && !busy;
    assign cfg_write = i_cfg_valid && o_cfg_ready;
    assign count     = f_eff(r_block_size, r_block_count);

    // Link memory: the next link of each freed block.
    fbpa_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(r_item.free_index)),
        .i_wr_data (r_head),
        .i_rd_en   (rd_en),
        .i_rd_addr (AW'(r_head)),
        .o_rd_data (rd_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbpa_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = fbpa_pkg::S_EXEC;
                end
            end
            fbpa_pkg::S_EXEC: begin
                n_state = fbpa_pkg::S_IDLE;
            end
            default: begin
                n_state = fbpa_pkg::S_IDLE;
            end
        endcase
    end

    // Controller outputs. The head link is read on every start transfer.
    always_comb begin
        busy        = (r_state == fbpa_pkg::S_EXEC);
        o_cfg_ready = (r_state == fbpa_pkg::S_IDLE);
        rd_en       = accept;
    end

    // Request checks and pool update, using the link read issued at the start transfer.
    always_comb begin
        n_head      = r_head;
        n_untouched = r_untouched;
        n_free      = r_free;
        wr_en       = 1'b0;
        status      = fbpa_pkg::ST_OK;
        pick        = '0;
        n_done      = 1'b0;
        n_result    = r_result;

        if (r_state == fbpa_pkg::S_EXEC) begin
            if (r_item.mode == fbpa_pkg::MODE_ALLOC) begin
                if (r_item.req_size == 16'd0) begin
                    status = fbpa_pkg::ST_ZERO_SIZE;
                end else if (count == 11'd0) begin
                    status = fbpa_pkg::ST_UNCONFIG;
                end else if (r_item.req_alignment != 13'd0 &&
                             r_item.req_alignment > r_max_align) begin
                    status = fbpa_pkg::ST_ALIGNMENT;
                end else if (r_item.req_size > r_block_size) begin
                    status = fbpa_pkg::ST_TOO_BIG;
                end else if (r_free == 11'd0) begin
                    status = r_item.no_fail ? fbpa_pkg::ST_FATAL_EMPTY : fbpa_pkg::ST_EMPTY;
                end else begin
                    // Pop the freed stack, or else take the lowest never-used block.
                    if (r_head < END_MARK) begin
                        pick   = r_head;
                        n_head = rd_data;
                    end else begin
                        pick        = r_untouched;
                        n_untouched = IW'(r_untouched + 1'b1);
                    end
                    n_free = r_free - 11'd1;
                end
            end else begin
                if (!r_item.handle_present) begin
                    status = fbpa_pkg::ST_NULL_IGNORE;
                end else if ({1'b0, r_item.free_index} >= count) begin
                    status = fbpa_pkg::ST_OUTSIDE;
                end else if (r_free >= count) begin
                    status = fbpa_pkg::ST_DOUBLE_FREE;
                end else begin
                    // Push the block onto the freed stack.
                    wr_en  = 1'b1;
                    n_head = IW'(r_item.free_index);
                    n_free = r_free + 11'd1;
                end
            end

            n_done                = 1'b1;
            n_result.status       = status;
            n_result.block_index  = 10'(pick);
            n_result.clear_length = (r_item.mode == fbpa_pkg::MODE_ALLOC &&
                                     status == fbpa_pkg::ST_OK &&
                                     r_item.zero_fill) ? r_item.req_size : 16'd0;
            n_result.free_blocks  = n_free;
            n_result.used_blocks  = count - n_free;
        end
    end

    // Configuration registers.
    always_comb begin
        n_block_size  = r_block_size;
        n_block_count = r_block_count;
        n_max_align   = r_max_align;
        if (cfg_write) begin
            case (i_cfg_index)
                fbpa_pkg::CFG_BLOCK_SIZE:    n_block_size  = i_cfg_data;
                fbpa_pkg::CFG_BLOCK_COUNT:   n_block_count = 11'(i_cfg_data);
                fbpa_pkg::CFG_MAX_ALIGNMENT: n_max_align   = 13'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Control and pool registers. A write to a defined register restarts the pool.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fbpa_pkg::S_IDLE;
            r_done        <= 1'b0;
            r_block_size  <= fbpa_pkg::BLOCK_SIZE_RST;
            r_block_count <= fbpa_pkg::BLOCK_COUNT_RST;
            r_max_align   <= fbpa_pkg::MAX_ALIGNMENT_RST;
            r_head        <= END_MARK;
            r_untouched   <= '0;
            r_free        <= f_eff(fbpa_pkg::BLOCK_SIZE_RST, fbpa_pkg::BLOCK_COUNT_RST);
        end else begin
            r_state       <= n_state;
            r_done        <= n_done;
            r_block_size  <= n_block_size;
            r_block_count <= n_block_count;
            r_max_align   <= n_max_align;
            if (cfg_write && i_cfg_index <= fbpa_pkg::CFG_MAX_ALIGNMENT) begin
                r_head      <= END_MARK;
                r_untouched <= '0;
                r_free      <= f_eff(n_block_size, n_block_count);
            end else begin
                r_head      <= n_head;
                r_untouched <= n_untouched;
                r_free      <= n_free;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // A result strobe always follows an execute cycle.
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == fbpa_pkg::S_EXEC))
        else $error("result strobe without an execute cycle");

    // A start transfer makes the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("start transfer did not raise busy");

    // The free count never exceeds the effective block count.
    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= count)
        else $error("free count above effective block count");

    // The stack head is a block index or the end mark.
    a_head_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= END_MARK)
        else $error("stack head out of range");

endmodule

// File: bench/fixed_block_pool_allocator_tb.sv
// Self-checking testbench for the fixed block pool allocator with a built-in pool predictor.
module fixed_block_pool_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_DEPTH = fbpa_pkg::MAX_BLOCKS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    fbpa_pkg::t_item   i_item = '0;
    logic              o_done;
    fbpa_pkg::t_result o_result;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index = '0;
    logic [15:0]       i_cfg_data = '0;

    // Predicted pool: register copies and the free-list state.
    logic [15:0] cfg_block_size;
    logic [10:0] cfg_block_count;
    logic [12:0] cfg_max_align;
    logic [10:0] link_copy [POOL_DEPTH];
    logic [10:0] stack_top;
    logic [10:0] fresh_next;
    logic [10:0] blocks_free;

    // Results still owed by the block, and blocks the stimulus currently holds.
    fbpa_pkg::t_result pool_outcomes[$];
    int                held[$];

    int calm_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    fixed_block_pool_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fixed_block_pool_allocator: mismatch");
            $finish;
        end
    end

    // Number of blocks the pool really has; zero when it is unconfigured.
    function automatic int unsigned usable_blocks();
        if (cfg_block_size == 16'd0 || cfg_block_count == 11'd0) begin
            return 0;
        end
        return (cfg_block_count > POOL_DEPTH) ? POOL_DEPTH : int'(cfg_block_count);
    endfunction

    // Every block free again: empty freed stack, nothing handed out yet.
    function automatic void pool_restart();
        stack_top = 11'(POOL_DEPTH);
        fresh_next = 11'd0;
        blocks_free = 11'(usable_blocks());
    endfunction

    function automatic void pool_power_up();
        cfg_block_size = fbpa_pkg::BLOCK_SIZE_RST;
        cfg_block_count = fbpa_pkg::BLOCK_COUNT_RST;
        cfg_max_align = fbpa_pkg::MAX_ALIGNMENT_RST;
        pool_restart();
    endfunction

    // A register write restarts the pool; the spare index is ignored.
    function automatic void pool_config(input logic [1:0] idx, input logic [15:0] data);
        case (idx)
            fbpa_pkg::CFG_BLOCK_SIZE: begin
                cfg_block_size = data;
            end
            fbpa_pkg::CFG_BLOCK_COUNT: begin
                cfg_block_count = data[10:0];
            end
            fbpa_pkg::CFG_MAX_ALIGNMENT: begin
                cfg_max_align = data[12:0];
            end
            default: begin
            end
        endcase
        if (idx != CFG_UNUSED) begin
            pool_restart();
        end
    endfunction

    // Serves one request against the predicted pool and returns its outcome.
    function automatic fbpa_pkg::t_result pool_serve(input fbpa_pkg::t_item it);
        fbpa_pkg::t_result r;
        int unsigned       count;
        count = usable_blocks();
        r = '0;
        if (it.mode == fbpa_pkg::MODE_ALLOC) begin
            // Request checks, in priority order.
            if (it.req_size == 16'd0) begin
                r.status = fbpa_pkg::ST_ZERO_SIZE;
            end else if (count == 0) begin
                r.status = fbpa_pkg::ST_UNCONFIG;
            end else if (it.req_alignment != 13'd0 && it.req_alignment > cfg_max_align) begin
                r.status = fbpa_pkg::ST_ALIGNMENT;
            end else if (it.req_size > cfg_block_size) begin
                r.status = fbpa_pkg::ST_TOO_BIG;
            end else if (blocks_free == 11'd0) begin
                r.status = it.no_fail ? fbpa_pkg::ST_FATAL_EMPTY : fbpa_pkg::ST_EMPTY;
            end else begin
                // Most recently freed block first, else the lowest untouched one.
                r.status = fbpa_pkg::ST_OK;
                if (stack_top < POOL_DEPTH) begin
                    r.block_index = stack_top[9:0];
                    stack_top = link_copy[stack_top[9:0]];
                end else begin
                    r.block_index = fresh_next[9:0];
                    fresh_next = fresh_next + 11'd1;
                end
                blocks_free = blocks_free - 11'd1;
                if (it.zero_fill) begin
                    r.clear_length = it.req_size;
                end
            end
        end else begin
            if (!it.handle_present) begin
                r.status = fbpa_pkg::ST_NULL_IGNORE;
            end else if (it.free_index >= count) begin
                r.status = fbpa_pkg::ST_OUTSIDE;
            end else if (blocks_free >= count) begin
                r.status = fbpa_pkg::ST_DOUBLE_FREE;
            end else begin
                r.status = fbpa_pkg::ST_OK;
                link_copy[it.free_index] = stack_top;
                stack_top = {1'b0, it.free_index};
                blocks_free = blocks_free + 11'd1;
            end
        end
        r.free_blocks = blocks_free;
        r.used_blocks = 11'(count - int'(blocks_free));
        return r;
    endfunction

    // Request with every field random.
    function automatic fbpa_pkg::t_item random_item();
        fbpa_pkg::t_item it;
        it.mode = 1'($urandom);
        it.req_size = 16'($urandom);
        it.req_alignment = 13'($urandom_range(0, 4096));
        it.zero_fill = 1'($urandom);
        it.no_fail = 1'($urandom);
        it.handle_present = 1'($urandom);
        it.free_index = 10'($urandom);
        return it;
    endfunction

    // Allocate request; the fields it does not use stay random.
    function automatic fbpa_pkg::t_item alloc_req(input int unsigned size,
                                                  input int unsigned align,
                                                  input logic zfill, input logic nofail);
        fbpa_pkg::t_item it;
        it = random_item();
        it.mode = fbpa_pkg::MODE_ALLOC;
        it.req_size = 16'(size);
        it.req_alignment = 13'(align);
        it.zero_fill = zfill;
        it.no_fail = nofail;
        return it;
    endfunction

    // Free request; the fields it does not use stay random.
    function automatic fbpa_pkg::t_item free_req(input logic present, input int unsigned idx);
        fbpa_pkg::t_item it;
        it = random_item();
        it.mode = fbpa_pkg::MODE_FREE;
        it.handle_present = present;
        it.free_index = 10'(idx);
        return it;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    // Each result strobe is matched against the oldest owed outcome.
    always @(posedge i_clk) begin
        fbpa_pkg::t_result want;
        if (i_rst_n && o_done) begin
            if (pool_outcomes.size() == 0) begin
                report_mismatch("result strobe with no request outstanding");
            end else begin
                want = pool_outcomes.pop_front();
                check_field("status", o_result.status, want.status);
                check_field("block_index", o_result.block_index, want.block_index);
                check_field("clear_length", o_result.clear_length, want.clear_length);
                check_field("free_blocks", o_result.free_blocks, want.free_blocks);
                check_field("used_blocks", o_result.used_blocks, want.used_blocks);
            end
        end
    end

    // Sends one request after a random gap, with occasional back-to-back bursts.
    // Start is left high on return so that a following request with no gap
    // keeps it high; whoever stops sending lowers it.
    task automatic send_item(input fbpa_pkg::t_item it, output fbpa_pkg::t_result outcome);
        int gap;
        if (calm_left > 0) begin
            gap = 0;
            calm_left--;
        end else begin
            gap = $urandom_range(0, 17);
            if ($urandom_range(0, 15) == 0) begin
                calm_left = $urandom_range(10, 40);
            end
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        outcome = pool_serve(it);
        pool_outcomes.push_back(outcome);
    endtask

    // Stops sending and waits until the block has answered everything.
    task automatic drain();
        start <= 1'b0;
        while (pool_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register transfer; always preceded by a random idle gap.
    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        repeat ($urandom_range(1, 17)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pool_config(idx, data);
    endtask

    task automatic set_pool(input logic [15:0] size, input logic [15:0] count,
                            input logic [15:0] align);
        drain();
        held.delete();
        cfg_write(fbpa_pkg::CFG_BLOCK_SIZE, size);
        cfg_write(fbpa_pkg::CFG_BLOCK_COUNT, count);
        cfg_write(fbpa_pkg::CFG_MAX_ALIGNMENT, align);
    endtask

    // Mostly well-formed traffic: allocations that fit, frees of held blocks,
    // and a share of fully random requests.
    task automatic run_traffic(input int n);
        fbpa_pkg::t_item   it;
        fbpa_pkg::t_result outcome;
        int                pick;
        int                slot;
        int unsigned       size_cap;
        int unsigned       align_cap;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            it = random_item();
            if (pick < 35 && held.size() != 0) begin
                slot = $urandom_range(0, held.size() - 1);
                it = free_req(1'b1, held[slot]);
            end else if (pick < 80) begin
                size_cap = (cfg_block_size == 16'd0) ? 1 : int'(cfg_block_size);
                align_cap = (cfg_max_align > 13'd4096) ? 4096 : int'(cfg_max_align);
                if (align_cap == 0) begin
                    align_cap = 1;
                end
                it = alloc_req(($urandom_range(0, 7) == 0) ? size_cap
                                                           : $urandom_range(1, size_cap),
                               ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, align_cap),
                               1'($urandom), 1'($urandom));
            end
            send_item(it, outcome);
            // Keep the list of handed-out blocks in step with the pool.
            if (outcome.status == fbpa_pkg::ST_OK) begin
                if (it.mode == fbpa_pkg::MODE_ALLOC) begin
                    held.push_back(int'(outcome.block_index));
                end else begin
                    for (int j = 0; j < held.size(); j++) begin
                        if (held[j] == int'(it.free_index)) begin
                            held.delete(j);
                            break;
                        end
                    end
                end
            end
        end
    endtask

    // Request checks and their priority on the reset-default pool.
    task automatic test_request_checks();
        fbpa_pkg::t_result outcome;
        send_item(free_req(1'b1, 5), outcome);           // all blocks free: double free
        send_item(free_req(1'b0, 1023), outcome);        // null handle
        send_item(alloc_req(0, 16, 1'b1, 1'b1), outcome);
        send_item(alloc_req(17, 32, 1'b0, 1'b0), outcome); // alignment wins over size
        send_item(alloc_req(17, 16, 1'b0, 1'b0), outcome);
        send_item(alloc_req(65535, 4096, 1'b1, 1'b1), outcome);
        send_item(alloc_req(16, 0, 1'b1, 1'b1), outcome);
        send_item(alloc_req(1, 16, 1'b0, 1'b0), outcome);
        send_item(free_req(1'b1, 1023), outcome);        // a block never handed out
        send_item(free_req(1'b1, 0), outcome);
        send_item(alloc_req(8, 1, 1'b1, 1'b0), outcome);
        send_item(alloc_req(8, 1, 1'b1, 1'b0), outcome);
        send_item(alloc_req(8, 1, 1'b1, 1'b0), outcome);
    endtask

    // Running a two-block pool dry, with the widest block and alignment.
    task automatic test_exhaustion();
        fbpa_pkg::t_result outcome;
        set_pool(16'hFFFF, 16'd2, 16'd4096);
        send_item(alloc_req(65535, 4096, 1'b1, 1'b0), outcome);
        send_item(alloc_req(1, 0, 1'b0, 1'b0), outcome);
        send_item(alloc_req(1, 0, 1'b0, 1'b0), outcome);
        send_item(alloc_req(1, 0, 1'b0, 1'b1), outcome);
        send_item(free_req(1'b1, 2), outcome);
        send_item(free_req(1'b1, 1), outcome);
        send_item(free_req(1'b1, 0), outcome);
        send_item(free_req(1'b1, 0), outcome);
    endtask

    // Zero count and zero block size both leave the pool unconfigured.
    task automatic test_unconfigured();
        fbpa_pkg::t_result outcome;
        set_pool(16'd16, 16'd0, 16'd16);
        send_item(alloc_req(0, 0, 1'b0, 1'b0), outcome);
        send_item(alloc_req(1, 0, 1'b0, 1'b0), outcome);
        send_item(free_req(1'b1, 0), outcome);
        set_pool(16'd0, 16'd1024, 16'd16);
        send_item(alloc_req(1, 0, 1'b1, 1'b1), outcome);
    endtask

    task automatic test_default_pool_traffic();
        set_pool(fbpa_pkg::BLOCK_SIZE_RST, 16'(fbpa_pkg::BLOCK_COUNT_RST),
                 16'(fbpa_pkg::MAX_ALIGNMENT_RST));
        run_traffic(250);
    endtask

    // A write to the spare index must leave the pool as it is.
    task automatic test_ignored_register();
        drain();
        cfg_write(CFG_UNUSED, 16'($urandom));
        run_traffic(50);
    endtask

    task automatic test_small_pool_traffic();
        set_pool(16'hFFFF, 16'd3, 16'd4096);
        run_traffic(200);
    endtask

    // Smallest block and alignment with an oversized count that saturates.
    task automatic test_extreme_config_traffic();
        set_pool(16'd1, 16'hFFFF, 16'd1);
        run_traffic(150);
    endtask

    task automatic test_random_config_traffic();
        set_pool(16'($urandom_range(1, 65535)), 16'd1, 16'hFFFF);
        run_traffic(50);
        for (int r = 0; r < 2; r++) begin
            set_pool(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 40)),
                     16'($urandom_range(1, 4096)));
            run_traffic(50);
        end
    endtask

    task automatic test_unconfigured_traffic();
        set_pool(16'd0, 16'd1024, 16'd16);
        run_traffic(50);
    endtask

    initial begin
        pool_power_up();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_request_checks();
        test_exhaustion();
        test_unconfigured();
        test_default_pool_traffic();
        test_ignored_register();
        test_small_pool_traffic();
        test_extreme_config_traffic();
        test_random_config_traffic();
        test_unconfigured_traffic();

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("fixed_block_pool_allocator: match");
        end else begin
            $display("fixed_block_pool_allocator: mismatch");
        end
        $finish;
    end

endmodule
